// ===== hw/rtl/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

	// Datapath geometry
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;

	// Widths fixed by the register map and the result fields
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int COLOR_W   = 24;
	localparam int ADDR_W    = 24;

	// Derived widths
	localparam int STEP_W = COORD_BITS;                 // longer axis span
	localparam int LEFT_W = COORD_BITS + 1;             // span + 1 pixels
	localparam int DIVD_W = COORD_BITS + FRAC_BITS;     // scaled delta plus rounding
	localparam int QUO_W  = FRAC_BITS + 1;              // increment magnitude, at most 1.0
	localparam int REM_W  = COORD_BITS;                 // remainder stays below the span
	localparam int INC_W  = FRAC_BITS + 2;              // signed increment
	localparam int POS_W  = COORD_BITS + FRAC_BITS + 1; // signed position
	localparam int PIX_W  = POS_W + 1 - FRAC_BITS;      // signed rounded coordinate
	localparam int CMP_W  = (PIX_W - 1 > CFG_W) ? PIX_W - 1 : CFG_W;
	localparam int CNT_W  = $clog2(QUO_W);

	localparam logic [POS_W:0]       POS_HALF = (POS_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [CNT_W-1:0]     DIV_LAST = CNT_W'(QUO_W - 1);
	localparam logic [CFG_W-1:0]     WIDTH_RST  = CFG_W'(500);
	localparam logic [CFG_W-1:0]     HEIGHT_RST = CFG_W'(500);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		op_t                          operation;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic        [COLOR_W-1:0]    line_color;
	} dlr_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic                         in_bounds;
		logic        [ADDR_W-1:0]     byte_address;
		logic        [COLOR_W-1:0]    pixel_color;
		logic                         last_pixel;
	} dlr_out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture endpoints, spans and colour
		logic tick;    // emit a pixel if a line is active
		logic prep;    // form the dividends
		logic step;    // one restoring-division step on both lanes
		logic finish;  // write the signed increments
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic s1_free;
	} dp_status_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] shf;
	} div_lane_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dlr_ctrl.sv =====
`default_nettype none

module dlr_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire dlr_pkg::op_t        operation,
	output logic                     in_stall,
	input  wire dlr_pkg::dp_status_t status,
	output dlr_pkg::dp_cmd_t         cmd
);
	import dlr_pkg::*;

	ctl_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	// Loads need only the controller; ticks also need a free first stage
	assign in_stall = !((state_q == ST_IDLE) &&
		((operation == OP_LOAD) || status.s1_free));
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_LOAD)) begin
					state_nxt = ST_PREP;
				end
			end
			ST_PREP:   state_nxt = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept && (operation == OP_LOAD);
				cmd.tick = accept && (operation == OP_TICK);
			end
			ST_PREP:   cmd.prep = 1'b1;
			ST_DIV:    cmd.step = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dlr_datapath.sv =====
`default_nettype none

module dlr_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dlr_pkg::dp_cmd_t          cmd,
	output dlr_pkg::dp_status_t            status,
	input  wire dlr_pkg::dlr_in_t          in_data,
	input  wire logic [dlr_pkg::CFG_W-1:0] frame_width,
	input  wire logic [dlr_pkg::CFG_W-1:0] frame_height,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output dlr_pkg::dlr_out_t              out_data
);
	import dlr_pkg::*;

	function automatic div_lane_t div_step(div_lane_t l, logic [STEP_W-1:0] d);
		logic [REM_W:0] t;
		div_lane_t      r;
		t = {l.rem, l.shf[QUO_W-1]} - {1'b0, d};
		if (!t[REM_W]) begin
			r.rem = t[REM_W-1:0];
			r.shf = {l.shf[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = {l.rem[REM_W-2:0], l.shf[QUO_W-1]};
			r.shf = {l.shf[QUO_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_lane_t div_init(logic [COORD_BITS-1:0] mag,
			logic [STEP_W-1:0] d);
		logic [DIVD_W-1:0] n;
		div_lane_t         r;
		n = {mag, FRAC_BITS'(0)} + DIVD_W'(d >> 1);
		r.rem = REM_W'(n[DIVD_W-1:QUO_W]);
		r.shf = n[QUO_W-1:0];
		return r;
	endfunction

	function automatic logic [INC_W-1:0] make_inc(logic [QUO_W-1:0] q, logic neg,
			logic zero);
		logic [INC_W-1:0] m;
		m = INC_W'(q);
		if (zero) begin
			return '0;
		end
		return neg ? -m : m;
	endfunction

	// Add one half, then truncate toward zero
	function automatic logic [PIX_W-1:0] to_pixel(logic [POS_W-1:0] pos);
		logic [POS_W:0] s;
		logic [POS_W:0] n;
		s = {pos[POS_W-1], pos} + POS_HALF;
		n = -s;
		if (!s[POS_W]) begin
			return s[POS_W:FRAC_BITS];
		end
		return -(n[POS_W:FRAC_BITS]);
	endfunction

	// Line set-up
	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      ax, ay, steps;

	logic [COORD_BITS-1:0] mag_x_q, mag_y_q;
	logic                  neg_x_q, neg_y_q;
	logic [STEP_W-1:0]     steps_q;
	div_lane_t             lane_x_q, lane_y_q;

	// Walk state
	logic [INC_W-1:0]   inc_x_q, inc_y_q;
	logic [POS_W-1:0]   pos_x_q, pos_y_q;
	logic [LEFT_W-1:0]  left_q;
	logic               active_q;
	logic [COLOR_W-1:0] color_q;

	// Rounded pixel and bound check
	logic [PIX_W-1:0] px, py;
	logic [CMP_W-1:0] px_mag, py_mag;
	logic             inb;
	logic             emit;

	logic                  valid_s1, inb_s1, last_s1;
	logic [COORD_BITS-1:0] pix_x_s1, pix_y_s1;
	logic [CFG_W-1:0]      ax_s1, ay_s1;
	logic [COLOR_W-1:0]    color_s1;

	logic              advance;
	logic [ADDR_W-1:0] prod, sum, addr;

	assign dx = (COORD_BITS + 1)'(in_data.end_x) - (COORD_BITS + 1)'(in_data.start_x);
	assign dy = (COORD_BITS + 1)'(in_data.end_y) - (COORD_BITS + 1)'(in_data.start_y);
	assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	assign steps = (ax > ay) ? ax : ay;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_x_q <= ax;
			mag_y_q <= ay;
			neg_x_q <= dx[COORD_BITS];
			neg_y_q <= dy[COORD_BITS];
			steps_q <= steps;
			color_q <= in_data.line_color;
		end
		if (cmd.prep) begin
			lane_x_q <= div_init(mag_x_q, steps_q);
			lane_y_q <= div_init(mag_y_q, steps_q);
		end else if (cmd.step) begin
			lane_x_q <= div_step(lane_x_q, steps_q);
			lane_y_q <= div_step(lane_y_q, steps_q);
		end
	end

	assign px = to_pixel(pos_x_q);
	assign py = to_pixel(pos_y_q);
	assign px_mag = CMP_W'(px[PIX_W-2:0]);
	assign py_mag = CMP_W'(py[PIX_W-2:0]);
	assign inb = !px[PIX_W-1] && !py[PIX_W-1] &&
		(px_mag < CMP_W'(frame_width)) && (py_mag < CMP_W'(frame_height));
	assign emit = cmd.tick && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= '0;
		end else if (cmd.load) begin
			active_q <= 1'b1;
			left_q   <= LEFT_W'(steps) + LEFT_W'(1);
		end else if (emit) begin
			left_q <= left_q - LEFT_W'(1);
			if (left_q == LEFT_W'(1)) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_x_q <= {in_data.start_x[COORD_BITS-1], in_data.start_x, FRAC_BITS'(0)};
			pos_y_q <= {in_data.start_y[COORD_BITS-1], in_data.start_y, FRAC_BITS'(0)};
		end else if (emit) begin
			pos_x_q <= pos_x_q + {{(POS_W - INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
			pos_y_q <= pos_y_q + {{(POS_W - INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
		end
		if (cmd.finish) begin
			inc_x_q <= make_inc(lane_x_q.shf, neg_x_q, steps_q == '0);
			inc_y_q <= make_inc(lane_y_q.shf, neg_y_q, steps_q == '0);
		end
	end

	// Two-stage pixel pipe: rounding and bounds, then address
	assign advance = !out_valid || !out_stall;
	assign status.s1_free = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_x_s1 <= px[COORD_BITS-1:0];
			pix_y_s1 <= py[COORD_BITS-1:0];
			ax_s1    <= px_mag[CFG_W-1:0];
			ay_s1    <= py_mag[CFG_W-1:0];
			inb_s1   <= inb;
			last_s1  <= (left_q == LEFT_W'(1));
			color_s1 <= color_q;
		end
	end

	assign prod = ADDR_W'(ay_s1) * ADDR_W'(frame_width);
	assign sum  = prod + ADDR_W'(ax_s1);
	assign addr = sum + {sum[ADDR_W-2:0], 1'b0};

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data.pixel_x      <= pix_x_s1;
			out_data.pixel_y      <= pix_y_s1;
			out_data.in_bounds    <= inb_s1;
			out_data.byte_address <= inb_s1 ? addr : '0;
			out_data.pixel_color  <= color_s1;
			out_data.last_pixel   <= last_s1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dda_line_rasterizer_unit.sv =====
`default_nettype none
// DDA line rasteriser.
// Input channel (in_valid/in_stall/in_data): a beat with operation LOAD gives
// two endpoints and a colour; a beat with operation TICK asks for the next
// pixel of the loaded line. A TICK with no line in progress is taken and
// dropped. A LOAD replaces any line still in progress and gives no result.
// Output channel (out_valid/out_stall/out_data): one beat per pixel with the
// rounded coordinates, the bound flag, the RGB byte address, the colour and
// a mark on the final pixel. A line of span S yields S+1 pixels.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): frame width and
// height; always ready, write only while the block is idle.
// Throughput: TICK beats go at one per cycle while no LOAD is in progress and
// the first stage is free. A LOAD is captured on its own beat, then stalls the
// input through one set-up, 17 restoring-division steps (one quotient bit per
// step on both axes at once) and one finish step that signs the increments.
// Pipeline: a TICK's pixel is registered after rounding and bound check, then
// the address multiply goes into the output register.
// Back-pressure: while out_stall holds, the output register and the first
// stage hold their beats; the input stalls only once both are full.
// Reset: no line is active, frame width and height return to 500.
module dda_line_rasterizer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire dlr_pkg::dlr_in_t              in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output dlr_pkg::dlr_out_t                  out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dlr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dlr_pkg::CFG_W-1:0]     cfg_data
);
	import dlr_pkg::*;

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	dp_cmd_t          cmd;
	dp_status_t       status;

	// Register writes are always accepted and registered into the frame registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: begin
					frame_width_q <= frame_width_q;
				end
			endcase
		end
	end

	// Sequencer: accepts beats, runs the increment division
	dlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (in_data.operation),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Set-up, divider lanes, position walk and pixel pipe
	dlr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_data      (in_data),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

	// At most one command is issued per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.tick, cmd.prep, cmd.step, cmd.finish}))
		else $error("controller issued more than one datapath command");

	// A load keeps the input stalled while the increments are formed
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (in_data.operation == OP_LOAD)) |=> in_stall)
		else $error("input taken during increment division");

	// An out-of-bounds pixel carries a zero address
	a_oob_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.in_bounds) |-> (out_data.byte_address == '0))
		else $error("address not cleared on out-of-bounds pixel");

	// No fresh pixel beat appears straight after the division set-up
	a_pixel_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> !$past(cmd.prep))
		else $error("pixel beat appeared during division set-up");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
	import dlr_pkg::*;

	// Cycles without any accepted beat before the run is declared hung. The
	// longest legitimate silence is a long sender gap on top of an increment
	// division and a long receiver stall, or the deliberate output hold below.
	localparam int QUIET_LIMIT = 3000;
	// Cycles to let a trailing LOAD (its increment division) or a dropped TICK
	// clear the block before a register write or the end of the run.
	localparam int SETTLE_CYCLES = 32;
	// Length of the deliberate output hold that backs the block up.
	localparam int HOLD_CYCLES = 90;
	// Input beats per frame setting in the random part.
	localparam int BEATS_PER_PHASE = 80;
	localparam int PHASES = 8;
	localparam int MAX_PRINTS = 200;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	dlr_in_t in_data;
	logic out_valid;
	logic out_stall;
	dlr_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dda_line_rasterizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Own copy of the rasteriser state and the frame registers.
	bit line_live;
	longint left_to_go;
	longint pos_x, pos_y;
	longint inc_x, inc_y;
	logic [COLOR_W-1:0] held_rgb;
	logic [CFG_W-1:0] fr_w, fr_h;

	dlr_out_t pixels_due[$];

	int errors;
	int beats_in;
	int lines_loaded;
	int pixels_seen;
	int settings_used;
	int input_held;
	int quiet;
	bit calm;
	int hold_len;

	// Directed opening: the expected pixel is typed in only where it is plain
	// from the rounding rule; the other rows go through the line tracer.
	typedef struct {
		op_t         op;
		int          sx;
		int          sy;
		int          ex;
		int          ey;
		int unsigned rgb;
		bit          typed;
		dlr_out_t    want;
	} walk_row_t;

	localparam int WALK_ROWS = 21;

	walk_row_t opening [WALK_ROWS] = '{
		// tick straight after reset: no line, so nothing comes out
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		// zero-length line at the origin: one pixel, in bounds, last
		'{OP_LOAD, 0, 0, 0, 0, 32'hFFFFFF, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b1,
			'{12'sd0, 12'sd0, 1'b1, 24'd0, 24'hFFFFFF, 1'b1}},
		// line already finished: tick is dropped
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		// far corner of the default 500x500 frame
		'{OP_LOAD, 499, 499, 499, 499, 32'h000000, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b1,
			'{12'sd499, 12'sd499, 1'b1, 24'd749997, 24'h000000, 1'b1}},
		// one column past the right edge
		'{OP_LOAD, 500, 0, 500, 0, 32'h123456, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b1,
			'{12'sd500, 12'sd0, 1'b0, 24'd0, 24'h123456, 1'b1}},
		// most negative corner: -2048 + 0.5 truncates toward zero to -2047
		'{OP_LOAD, -2048, -2048, -2048, -2048, 32'h800001, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b1,
			'{-12'sd2047, -12'sd2047, 1'b0, 24'd0, 24'h800001, 1'b1}},
		// most positive corner
		'{OP_LOAD, 2047, 2047, 2047, 2047, 32'h7FFFFE, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b1,
			'{12'sd2047, 12'sd2047, 1'b0, 24'd0, 24'h7FFFFE, 1'b1}},
		// full-span diagonal, left unfinished and replaced by the next load
		'{OP_LOAD, -2048, 2047, 2047, -2048, 32'hAAAAAA, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		// short line through negative positions that round onto zero
		'{OP_LOAD, -2, -1, 1, 2, 32'h555555, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0},
		'{OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0}
	};

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("MISMATCH: %s", what);
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("pixel %0d %s: got %0d, want %0d",
				pixels_seen, name, got, want));
	endtask

	function automatic longint unit_step(input longint delta, input longint span);
		longint q;
		if (span == 0)
			return 0;
		q = (((delta < 0 ? -delta : delta) <<< FRAC_BITS) + span / 2) / span;
		return delta < 0 ? -q : q;
	endfunction

	// Add one half, then truncate toward zero (not floor).
	function automatic longint to_coord(input longint pos);
		longint s;
		s = pos + (longint'(1) <<< (FRAC_BITS - 1));
		if (s >= 0)
			return s >>> FRAC_BITS;
		return -((-s) >>> FRAC_BITS);
	endfunction

	// Advance the traced line by one beat; return 1 when it yields a pixel.
	function automatic bit trace_line(input dlr_in_t b, output dlr_out_t pix);
		longint sx, sy, dx, dy, ax, ay, span, cx, cy, addr;
		bit inb;
		pix = '0;
		if (b.operation == OP_LOAD) begin
			sx = longint'($signed(b.start_x));
			sy = longint'($signed(b.start_y));
			dx = longint'($signed(b.end_x)) - sx;
			dy = longint'($signed(b.end_y)) - sy;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			span = ax > ay ? ax : ay;
			inc_x = unit_step(dx, span);
			inc_y = unit_step(dy, span);
			pos_x = sx <<< FRAC_BITS;
			pos_y = sy <<< FRAC_BITS;
			left_to_go = span + 1;
			held_rgb = b.line_color;
			line_live = 1'b1;
			return 1'b0;
		end
		if (!line_live)
			return 1'b0;
		cx = to_coord(pos_x);
		cy = to_coord(pos_y);
		inb = cx >= 0 && cy >= 0 && cx < longint'(fr_w) && cy < longint'(fr_h);
		addr = inb ? (cy * longint'(fr_w) + cx) * 3 : 0;
		left_to_go--;
		pix.pixel_x = COORD_BITS'(cx);
		pix.pixel_y = COORD_BITS'(cy);
		pix.in_bounds = inb;
		pix.byte_address = ADDR_W'(addr);
		pix.pixel_color = held_rgb;
		pix.last_pixel = (left_to_go == 0);
		if (left_to_go == 0)
			line_live = 1'b0;
		pos_x += inc_x;
		pos_y += inc_y;
		return 1'b1;
	endfunction

	// Mostly back to back, some short gaps, the odd long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	// A start point a few pixels either side of the frame.
	function automatic int near_frame(input int lim);
		return clamp_coord(int'($urandom_range(0, lim + 8)) - 4);
	endfunction

	// Offer one input beat, wait for it to be taken, then trace it.
	task automatic send_beat(input dlr_in_t b, input bit typed, input dlr_out_t want);
		dlr_out_t traced;
		int g;
		g = calm ? 0 : pick_gap();
		repeat (g) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_in++;
		if (b.operation == OP_LOAD)
			lines_loaded++;
		if (trace_line(b, traced)) begin
			if (typed)
				traced = want;
			pixels_due = {pixels_due, traced};
		end
	endtask

	// A tick carries junk in the fields it ignores.
	task automatic send_tick();
		logic [95:0] raw;
		dlr_in_t b;
		raw = {$urandom, $urandom, $urandom};
		b = raw[$bits(dlr_in_t)-1:0];
		b.operation = OP_TICK;
		send_beat(b, 1'b0, '0);
	endtask

	task automatic send_load(input int sx, input int sy, input int ex, input int ey,
			input logic [COLOR_W-1:0] rgb);
		dlr_in_t b;
		b = '0;
		b.operation = OP_LOAD;
		b.start_x = COORD_BITS'(sx);
		b.start_y = COORD_BITS'(sy);
		b.end_x = COORD_BITS'(ex);
		b.end_y = COORD_BITS'(ey);
		b.line_color = rgb;
		send_beat(b, 1'b0, '0);
	endtask

	// One random sequence: mostly a well-formed line with its ticks, now and
	// then cut short or overrun, sometimes plain noise.
	task automatic random_sequence();
		logic [95:0] raw;
		dlr_in_t b;
		int r, reach, sx, sy, ex, ey, ddx, ddy, n;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			// fully random load, possibly a huge span: take a few pixels only
			raw = {$urandom, $urandom, $urandom};
			b = raw[$bits(dlr_in_t)-1:0];
			b.operation = OP_LOAD;
			send_beat(b, 1'b0, '0);
			repeat ($urandom_range(0, 4))
				send_tick();
		end else if (r < 10) begin
			repeat ($urandom_range(1, 3))
				send_tick();
		end else begin
			r = $urandom_range(0, 99);
			reach = r < 70 ? $urandom_range(0, 12) :
				r < 97 ? $urandom_range(13, 80) : $urandom_range(100, 250);
			if ($urandom_range(0, 1)) begin
				sx = near_frame(int'(fr_w));
				sy = near_frame(int'(fr_h));
			end else begin
				sx = int'($urandom_range(0, 4095)) - 2048;
				sy = int'($urandom_range(0, 4095)) - 2048;
			end
			ddx = $urandom_range(0, 1) ? reach : -reach;
			ddy = int'($urandom_range(0, 2 * reach)) - reach;
			if ($urandom_range(0, 1)) begin
				n = ddx;
				ddx = ddy;
				ddy = n;
			end
			ex = clamp_coord(sx + ddx);
			ey = clamp_coord(sy + ddy);
			send_load(sx, sy, ex, ey, COLOR_W'($urandom));
			ddx = ex > sx ? ex - sx : sx - ex;
			ddy = ey > sy ? ey - sy : sy - ey;
			n = (ddx > ddy ? ddx : ddy) + 1;
			r = $urandom_range(0, 99);
			if (r < 10)
				n = $urandom_range(0, n - 1);
			else if (r < 20)
				n += $urandom_range(1, 3);
			repeat (n)
				send_tick();
		end
	endtask

	// Drop valid, let every expected pixel out, then give the block time to
	// finish any division or dropped tick that has no pixel to show for it.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_FRAME_WIDTH)
			fr_w = value;
		else
			fr_h = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		drain_block();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		settings_used++;
	endtask

	// Receiver: random stall runs, none while calm, and a counted hold when
	// one is asked for.
	initial begin
		int stall_run;
		bit stalling;
		stall_run = 0;
		stalling = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				if (stall_run == 0) begin
					stalling = $urandom_range(0, 99) < 35;
					stall_run = stalling ? pick_gap() + 1 : $urandom_range(1, 8);
				end
				stall_run--;
				out_stall <= stalling;
			end
		end
	end

	// Pixel checker: every accepted output beat against the oldest expectation.
	always @(posedge clk) begin
		dlr_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			if (pixels_due.size() == 0) begin
				report_mismatch($sformatf("pixel %0d arrived with nothing expected",
					pixels_seen));
			end else begin
				want = pixels_due.pop_front();
				check_field("pixel_x", longint'(out_data.pixel_x), longint'(want.pixel_x));
				check_field("pixel_y", longint'(out_data.pixel_y), longint'(want.pixel_y));
				check_field("in_bounds", longint'(out_data.in_bounds),
					longint'(want.in_bounds));
				check_field("byte_address", longint'(out_data.byte_address),
					longint'(want.byte_address));
				check_field("pixel_color", longint'(out_data.pixel_color),
					longint'(want.pixel_color));
				check_field("last_pixel", longint'(out_data.last_pixel),
					longint'(want.last_pixel));
			end
		end
	end

	// Watchdog: count cycles with no beat moving on any channel.
	always @(posedge clk) begin
		if (in_valid && in_stall)
			input_held++;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		dlr_in_t b;
		int target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		calm = 1'b0;
		hold_len = 0;
		errors = 0;
		beats_in = 0;
		lines_loaded = 0;
		pixels_seen = 0;
		settings_used = 1;
		input_held = 0;
		quiet = 0;
		line_live = 1'b0;
		left_to_go = 0;
		pos_x = 0;
		pos_y = 0;
		inc_x = 0;
		inc_y = 0;
		held_rgb = '0;
		fr_w = WIDTH_RST;
		fr_h = HEIGHT_RST;

		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table on the reset frame size.
		foreach (opening[i]) begin
			b = '0;
			b.operation = opening[i].op;
			b.start_x = COORD_BITS'(opening[i].sx);
			b.start_y = COORD_BITS'(opening[i].sy);
			b.end_x = COORD_BITS'(opening[i].ex);
			b.end_y = COORD_BITS'(opening[i].ey);
			b.line_color = COLOR_W'(opening[i].rgb);
			send_beat(b, opening[i].typed, opening[i].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: set_frame(12'd640, 12'd480);
				2: set_frame(12'd1, 12'd1);
				3: set_frame(12'd4095, 12'd4095);   // addresses wrap past 2^24
				4: set_frame(12'd0, 12'd300);       // zero width: nothing in bounds
				5: set_frame(12'd2047, 12'd0);      // zero height
				6: set_frame(CFG_W'($urandom_range(1, 2047)),
					CFG_W'($urandom_range(1, 2047)));
				7: set_frame(12'd500, 12'd500);
				default: ;
			endcase
			// every third phase runs with no idling on either side
			calm = (phase % 3 == 1);
			if (phase == 1) begin
				// Hold the output long enough that the pipeline fills and the
				// input stalls, while ticks keep coming back to back.
				send_load(0, 0, 150, 40, COLOR_W'($urandom));
				hold_len = HOLD_CYCLES;
				repeat (151)
					send_tick();
			end
			target = beats_in + BEATS_PER_PHASE;
			while (beats_in < target)
				random_sequence();
		end

		calm = 1'b0;
		drain_block();
		if (pixels_due.size() != 0)
			report_mismatch($sformatf("%0d expected pixels never arrived",
				pixels_due.size()));

		$display("Run: %0d input beats (%0d line loads), %0d pixels checked, %0d frame sizes",
			beats_in, lines_loaded, pixels_seen, settings_used);
		$display("Output held %0d cycles once; input back-pressured on %0d cycles; %0d errors",
			HOLD_CYCLES, input_held, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
